FILE: src/assert_macros.svh
// assertion macros used by the checker module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define SBP_ASSERT_IMPL(lbl, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("sbp assertion failed");

// next-cycle implication, disabled while reset is asserted
`define SBP_ASSERT_NEXT(lbl, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("sbp assertion failed");

`endif

FILE: src/sbp_pkg.sv
// shared types, constants and counter helpers for the skewed branch predictor
package sbp_pkg;

  // default table geometry
  localparam int unsigned LocalIndexBitsDef   = 9;
  localparam int unsigned LocalHistoryBitsDef = 12;
  localparam int unsigned GlobalBitsDef       = 13;

  // reset value of every 2-bit counter: weakly not taken, or favor local
  localparam logic [1:0] CtrInit = 2'd1;
  localparam logic [1:0] CtrMax  = 2'd3;
  localparam logic [1:0] CtrMin  = 2'd0;

  // controller to datapath commands
  typedef struct packed {
    logic clear;   // write reset values at the sweep address and advance it
    logic start;   // capture the item, read history and global-indexed counters
    logic ctr_rd;  // read the local counter at the fetched local history
    logic finish;  // load the prediction and train when the item asks for it
  } sbp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic clear_last;  // sweep address is at its final entry
  } sbp_status_t;

  // counter predicts taken at 2 or 3
  function automatic logic ctr_taken(input logic [1:0] c);
    ctr_taken = c[1];
  endfunction

  // saturating step toward taken or not taken
  function automatic logic [1:0] ctr_move(input logic [1:0] c, input logic up);
    if (up) begin
      ctr_move = (c == CtrMax) ? CtrMax : c + 2'd1;
    end else begin
      ctr_move = (c == CtrMin) ? CtrMin : c - 2'd1;
    end
  endfunction

endpackage

FILE: src/sbp_ctrl.sv
// controller: reset sweep, item sequencing and output handshake
module sbp_ctrl import sbp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  input  sbp_status_t status_i,
  output sbp_cmd_t    cmd_o
);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_HIST  = 2'd2;
  localparam logic [1:0] ST_CTR   = 2'd3;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (status_i.clear_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = ST_HIST;
        end
      end
      ST_HIST: begin
        cmd_o.ctr_rd = 1'b1;
        state_d      = ST_CTR;
      end
      ST_CTR: begin
        // wait until the output register is free or being emptied
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  // output valid flag
  always_comb begin
    if (cmd_o.finish) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

FILE: src/sbp_dpath.sv
// datapath: history and counter tables, indexing, vote and training
module sbp_dpath import sbp_pkg::*; #(
  parameter int unsigned LOCAL_INDEX_BITS   = LocalIndexBitsDef,
  parameter int unsigned LOCAL_HISTORY_BITS = LocalHistoryBitsDef,
  parameter int unsigned GLOBAL_BITS        = GlobalBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  sbp_cmd_t    cmd_i,
  output sbp_status_t status_o,
  input  logic        kind_i,
  input  logic [31:0] pc_i,
  input  logic        taken_i,
  output logic        predict_taken_o
);

  localparam int unsigned LIB = LOCAL_INDEX_BITS;
  localparam int unsigned LHB = LOCAL_HISTORY_BITS;
  localparam int unsigned GB  = GLOBAL_BITS;
  localparam int unsigned ClrBitsA = (LIB > LHB) ? LIB : LHB;
  localparam int unsigned ClrBits  = (ClrBitsA > GB) ? ClrBitsA : GB;

  // table storage
  logic [LHB-1:0] lhist_mem [2**LIB];
  logic [1:0]     lctr_mem  [2**LHB];
  logic [1:0]     xctr_mem  [2**GB];
  logic [1:0]     actr_mem  [2**GB];
  logic [1:0]     cctr_mem  [2**GB];

  logic [ClrBits-1:0] clr_cnt_q;
  logic [GB-1:0]      ghist_q, ghist_d;
  logic [GB:0]        ghist_shift;
  logic [LHB:0]       lhist_shift;
  logic [LHB-1:0]     lhist_new;

  logic           kind_q, taken_q;
  logic [LIB-1:0] li_q;
  logic [GB-1:0]  xi_q, ai_q;
  logic [LHB-1:0] lhist_rd_q;
  logic [1:0]     lctr_rd_q, xctr_rd_q, actr_rd_q, cctr_rd_q;
  logic           pred_q;

  logic [LIB-1:0] li_w;
  logic [GB-1:0]  xi_w, ai_w;
  logic           p_local, p_xor, p_add, p_skew, use_skew, pred;
  logic           local_ok, skew_ok, train;

  // indexes of a new item
  assign li_w = pc_i[LIB-1:0];
  assign xi_w = pc_i[GB-1:0] ^ ghist_q;
  assign ai_w = pc_i[GB-1:0] + ghist_q;

  // votes and chosen prediction
  assign p_local  = ctr_taken(lctr_rd_q);
  assign p_xor    = ctr_taken(xctr_rd_q);
  assign p_add    = ctr_taken(actr_rd_q);
  assign p_skew   = (p_local & p_xor) | (p_local & p_add) | (p_xor & p_add);
  assign use_skew = ctr_taken(cctr_rd_q);
  assign pred     = use_skew ? p_skew : p_local;

  assign local_ok = (p_local == taken_q);
  assign skew_ok  = (p_skew == taken_q);
  assign train    = cmd_i.finish & kind_q;

  // shifted histories
  assign lhist_shift = {lhist_rd_q, taken_q};
  assign lhist_new   = lhist_shift[LHB-1:0];
  assign ghist_shift = {ghist_q, taken_q};
  assign ghist_d     = ghist_shift[GB-1:0];

  // reset sweep counter and global history
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
      ghist_q   <= '0;
    end else begin
      if (cmd_i.clear) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
      end
      if (train) begin
        ghist_q <= ghist_d;
      end
    end
  end

  assign status_o.clear_last = &clr_cnt_q;

  // item capture and prediction register
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      kind_q  <= kind_i;
      taken_q <= taken_i;
      li_q    <= li_w;
      xi_q    <= xi_w;
      ai_q    <= ai_w;
    end
    if (cmd_i.finish) begin
      pred_q <= pred;
    end
  end

  // local history table
  always_ff @(posedge clk_i) begin
    if (cmd_i.clear) begin
      lhist_mem[clr_cnt_q[LIB-1:0]] <= '0;
    end else if (train) begin
      lhist_mem[li_q] <= lhist_new;
    end
    if (cmd_i.start) begin
      lhist_rd_q <= lhist_mem[li_w];
    end
  end

  // local counter table
  always_ff @(posedge clk_i) begin
    if (cmd_i.clear) begin
      lctr_mem[clr_cnt_q[LHB-1:0]] <= CtrInit;
    end else if (train) begin
      lctr_mem[lhist_rd_q] <= ctr_move(lctr_rd_q, taken_q);
    end
    if (cmd_i.ctr_rd) begin
      lctr_rd_q <= lctr_mem[lhist_rd_q];
    end
  end

  // xor-indexed counter table
  always_ff @(posedge clk_i) begin
    if (cmd_i.clear) begin
      xctr_mem[clr_cnt_q[GB-1:0]] <= CtrInit;
    end else if (train) begin
      xctr_mem[xi_q] <= ctr_move(xctr_rd_q, taken_q);
    end
    if (cmd_i.start) begin
      xctr_rd_q <= xctr_mem[xi_w];
    end
  end

  // add-indexed counter table
  always_ff @(posedge clk_i) begin
    if (cmd_i.clear) begin
      actr_mem[clr_cnt_q[GB-1:0]] <= CtrInit;
    end else if (train) begin
      actr_mem[ai_q] <= ctr_move(actr_rd_q, taken_q);
    end
    if (cmd_i.start) begin
      actr_rd_q <= actr_mem[ai_w];
    end
  end

  // chooser table, trained only when local and skew disagree in correctness
  always_ff @(posedge clk_i) begin
    if (cmd_i.clear) begin
      cctr_mem[clr_cnt_q[GB-1:0]] <= CtrInit;
    end else if (train && (local_ok != skew_ok)) begin
      cctr_mem[ghist_q] <= ctr_move(cctr_rd_q, skew_ok);
    end
    if (cmd_i.start) begin
      cctr_rd_q <= cctr_mem[ghist_q];
    end
  end

  assign predict_taken_o = pred_q;

endmodule

FILE: src/skewed_branch_predictor_top.sv
// top level of the skewed branch predictor
//
//   channel | handshake               | payload
//   --------+-------------------------+------------------------
//   in      | in_valid_i / in_stall_o | kind_i, pc_i, taken_i
//   out     | out_valid_o/out_stall_i | predict_taken_o
//
// an item is worked in steps: accept with history and global-table reads, then the
// local counter read on the fetched history, then vote, output load and training.
// the local-history-then-local-counter memory read chain is why these steps are separate.
// after reset a clearing pass writes reset values into every table; no item is taken then.
// a stalled output holds the finished item in the last step until the register frees.
module skewed_branch_predictor_top import sbp_pkg::*; #(
  parameter int unsigned LOCAL_INDEX_BITS   = LocalIndexBitsDef,
  parameter int unsigned LOCAL_HISTORY_BITS = LocalHistoryBitsDef,
  parameter int unsigned GLOBAL_BITS        = GlobalBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        kind_i,
  input  logic [31:0] pc_i,
  input  logic        taken_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        predict_taken_o
);

  sbp_cmd_t    cmd;
  sbp_status_t status;

  // sequencing
  sbp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // tables and prediction logic
  sbp_dpath #(
    .LOCAL_INDEX_BITS   (LOCAL_INDEX_BITS),
    .LOCAL_HISTORY_BITS (LOCAL_HISTORY_BITS),
    .GLOBAL_BITS        (GLOBAL_BITS)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .kind_i          (kind_i),
    .pc_i            (pc_i),
    .taken_i         (taken_i),
    .predict_taken_o (predict_taken_o)
  );

endmodule

FILE: src/sbp_checker.sv
// port-level checker for the skewed branch predictor, bound to the top level
`include "assert_macros.svh"

module sbp_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i,
  input logic predict_taken_o
);

  // no item is taken while the tables are being cleared
  `SBP_ASSERT_IMPL(a_stall_after_reset, rst_ni, $rose(rst_ni), in_stall_o)

  // one item at a time: after an input transfer the input stalls before the next is taken
  `SBP_ASSERT_NEXT(a_busy_after_accept, rst_ni, in_valid_i && !in_stall_o, in_stall_o ##1 in_stall_o)

  // a new result appears only at the end of an item's work
  `SBP_ASSERT_IMPL(a_result_from_work, rst_ni, $rose(out_valid_o), $past(in_stall_o))

  // a stalled result holds
  `SBP_ASSERT_NEXT(a_out_hold, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(predict_taken_o))

endmodule

bind skewed_branch_predictor_top sbp_checker u_sbp_checker (.*);
